>>> rtl/bafnp_pkg.sv
// Shared types and constants for the BLE advertising flags/name parser.
// Used by every module in rtl/; no dependencies of its own.
package bafnp_pkg;

    // Longest payload the walker honors; report_length is clamped to it.
    localparam int unsigned MAX_PAYLOAD = 31;

    // AD structure type codes and flags bits.
    localparam logic [7:0] AD_FLAGS         = 8'h01;
    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;
    localparam logic [7:0] BIT_LIMITED      = 8'h01;
    localparam logic [7:0] BIT_GENERAL      = 8'h02;

    // Configuration register indexes.
    localparam logic CFG_DISCOVERY_MODE  = 1'b0;
    localparam logic CFG_MAX_NAME_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_TYPE  = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FLAGS = 2'd1,
        KIND_NAME  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_LIMITED = 2'd1,
        MODE_GENERAL = 2'd2,
        MODE_UNKNOWN = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] report_length;
        logic       first_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic       name_valid;
        logic [7:0] name_byte;
        logic       report_done;
        logic       accepted;
        logic       flags_found;
        logic [7:0] flags_value;
        logic       name_found;
    } t_out;

    typedef struct packed {
        t_mode      discovery_mode;
        logic [7:0] max_name_length;
    } t_cfg;

endpackage

>>> rtl/ble_adv_flags_name_parser.sv
// BLE advertising flags/name parser, top level: config registers, walker, result queue.
// Depends on bafnp_pkg, bafnp_walker and bafnp_out_fifo.
// Results are registered in the result queue; throughput is one byte per cycle
// unless the queue is full; the walker updates its state in one step and the
// two-entry result queue lets intake continue while a result waits.
// Reset (synchronous, active low): parse state cleared, discovery_mode = none,
// max_name_length = 255, result queue empty.
module ble_adv_flags_name_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Byte intake
    input  logic             i_valid,
    output logic             o_ready,
    input  bafnp_pkg::t_in   i_data,
    // Result delivery
    output logic             o_valid,
    input  logic             i_ready,
    output bafnp_pkg::t_out  o_data,
    // Configuration writes
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_wdata
);

    bafnp_pkg::t_cfg r_cfg;
    logic            accept;
    logic            w_res_valid;
    bafnp_pkg::t_out w_res;
    logic            q_full;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.discovery_mode  <= bafnp_pkg::MODE_NONE;
            r_cfg.max_name_length <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bafnp_pkg::CFG_DISCOVERY_MODE:
                    r_cfg.discovery_mode <= bafnp_pkg::t_mode'(i_cfg_wdata[1:0]);
                bafnp_pkg::CFG_MAX_NAME_LENGTH:
                    r_cfg.max_name_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Take a byte whenever the result queue has a free slot.
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    bafnp_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_data),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Push only bytes that produce a result (name byte or report end).
    bafnp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && w_res_valid),
        .i_wdata (w_res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    // A full queue always has something to deliver.
    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("queue full without a pending result");

    // A name byte is only ever emitted once the name record has been found.
    a_name_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.name_valid) |-> o_data.name_found)
        else $error("name byte without name_found");

    // Verdict only appears on the report's final result.
    a_verdict_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.report_done) |-> !o_data.accepted)
        else $error("accepted set outside report end");

    // A transferred byte that ends a report always lands in the queue next cycle.
    a_done_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.last_byte) |=> o_valid)
        else $error("report end lost");
`endif

endmodule

>>> rtl/bafnp_walker.sv
// Record walker: per-report parse state and the one-byte update step.
// Depends on bafnp_pkg.
module bafnp_walker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  bafnp_pkg::t_in   i_item,
    input  bafnp_pkg::t_cfg  i_cfg,
    output logic             o_res_valid,
    output bafnp_pkg::t_out  o_res
);

    logic [4:0]        r_pos,     n_pos;
    logic [7:0]        r_rem,     n_rem;
    bafnp_pkg::t_phase r_phase,   n_phase;
    bafnp_pkg::t_kind  r_kind,    n_kind;
    logic              r_stopped, n_stopped;
    logic              r_fseen,   n_fseen;
    logic [7:0]        r_fheld,   n_fheld;
    logic              r_nseen,   n_nseen;
    logic              r_nclosed, n_nclosed;

    always_comb begin
        logic [4:0] size;
        logic [7:0] rem_m1;
        logic       nv;
        logic [7:0] nb;
        logic       acc;

        n_pos     = r_pos;
        n_rem     = r_rem;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_stopped = r_stopped;
        n_fseen   = r_fseen;
        n_fheld   = r_fheld;
        n_nseen   = r_nseen;
        n_nclosed = r_nclosed;
        nv        = 1'b0;
        nb        = 8'd0;
        acc       = 1'b0;

        // Start of a report: drop whatever the old report left.
        if (i_item.first_byte) begin
            n_pos     = 5'd0;
            n_rem     = 8'd0;
            n_phase   = bafnp_pkg::PH_LEN;
            n_kind    = bafnp_pkg::KIND_OTHER;
            n_stopped = 1'b0;
            n_fseen   = 1'b0;
            n_fheld   = 8'd0;
            n_nseen   = 1'b0;
            n_nclosed = 1'b0;
        end

        size = i_item.report_length;
        if (32'(size) > bafnp_pkg::MAX_PAYLOAD) begin
            size = 5'(bafnp_pkg::MAX_PAYLOAD);
        end
        rem_m1 = n_rem - 8'd1;

        if (!n_stopped && (n_pos < size)) begin
            case (n_phase)
                bafnp_pkg::PH_LEN: begin
                    // Record must fit, length byte included.
                    if ((i_item.data_byte == 8'd0) ||
                        ({4'd0, n_pos} + 9'd1 + {1'b0, i_item.data_byte} > {4'd0, size})) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_rem   = i_item.data_byte;
                        n_phase = bafnp_pkg::PH_TYPE;
                    end
                end
                bafnp_pkg::PH_TYPE: begin
                    n_rem  = rem_m1;
                    n_kind = bafnp_pkg::KIND_OTHER;
                    if ((i_item.data_byte == bafnp_pkg::AD_FLAGS) && !n_fseen) begin
                        n_kind = bafnp_pkg::KIND_FLAGS;
                    end else if (((i_item.data_byte == bafnp_pkg::AD_NAME_SHORT) ||
                                  (i_item.data_byte == bafnp_pkg::AD_NAME_COMPLETE)) &&
                                 !n_nclosed) begin
                        n_nclosed = 1'b1;
                        if (rem_m1 <= i_cfg.max_name_length) begin
                            n_nseen = 1'b1;
                            n_kind  = bafnp_pkg::KIND_NAME;
                        end
                    end
                    n_phase = (rem_m1 != 8'd0) ? bafnp_pkg::PH_VALUE : bafnp_pkg::PH_LEN;
                end
                default: begin
                    if ((n_kind == bafnp_pkg::KIND_FLAGS) && !n_fseen) begin
                        n_fheld = i_item.data_byte;
                        n_fseen = 1'b1;
                    end else if (n_kind == bafnp_pkg::KIND_NAME) begin
                        nv = 1'b1;
                        nb = i_item.data_byte;
                    end
                    n_rem = rem_m1;
                    if (rem_m1 == 8'd0) begin
                        n_phase = bafnp_pkg::PH_LEN;
                    end
                end
            endcase
        end

        // Saturate the position counter.
        if (n_pos != 5'd31) begin
            n_pos = n_pos + 5'd1;
        end

        case (i_cfg.discovery_mode)
            bafnp_pkg::MODE_NONE:    acc = 1'b1;
            bafnp_pkg::MODE_LIMITED: acc = n_fseen && ((n_fheld & bafnp_pkg::BIT_LIMITED) != 8'd0);
            bafnp_pkg::MODE_GENERAL: acc = n_fseen &&
                ((n_fheld & (bafnp_pkg::BIT_LIMITED | bafnp_pkg::BIT_GENERAL)) != 8'd0);
            default:                 acc = 1'b0;
        endcase

        o_res_valid       = nv || i_item.last_byte;
        o_res.name_valid  = nv;
        o_res.name_byte   = nb;
        o_res.report_done = i_item.last_byte;
        o_res.accepted    = i_item.last_byte & acc;
        o_res.flags_found = n_fseen;
        o_res.flags_value = n_fheld;
        o_res.name_found  = n_nseen;

        // End of report: clear for the next one.
        if (i_item.last_byte) begin
            n_pos     = 5'd0;
            n_rem     = 8'd0;
            n_phase   = bafnp_pkg::PH_LEN;
            n_kind    = bafnp_pkg::KIND_OTHER;
            n_stopped = 1'b0;
            n_fseen   = 1'b0;
            n_fheld   = 8'd0;
            n_nseen   = 1'b0;
            n_nclosed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 5'd0;
            r_rem     <= 8'd0;
            r_phase   <= bafnp_pkg::PH_LEN;
            r_kind    <= bafnp_pkg::KIND_OTHER;
            r_stopped <= 1'b0;
            r_fseen   <= 1'b0;
            r_fheld   <= 8'd0;
            r_nseen   <= 1'b0;
            r_nclosed <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_stopped <= n_stopped;
            r_fseen   <= n_fseen;
            r_fheld   <= n_fheld;
            r_nseen   <= n_nseen;
            r_nclosed <= n_nclosed;
        end
    end

endmodule

>>> rtl/bafnp_out_fifo.sv
// Two-entry result queue: decouples the result side from byte intake.
// Depends on bafnp_pkg.
module bafnp_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bafnp_pkg::t_out  i_wdata,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output bafnp_pkg::t_out  o_data
);

    bafnp_pkg::t_out r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

>>> bench/adv_walk_checker.sv
// Checker for the BLE advertising flags/name parser: watches the byte, result and
// register ports, predicts each result and compares it with what the block delivers.
// Depends on bafnp_pkg for the payload structs, enums and type codes.
module adv_walk_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  bafnp_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  bafnp_pkg::t_out i_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_wdata,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bafnp_pkg::*;

    t_mode      mode;
    logic [7:0] name_limit;

    logic [4:0] pos;
    logic [7:0] remaining;
    t_phase     phase;
    t_kind      kind;
    logic       stopped;
    logic       flags_seen;
    logic [7:0] flags_held;
    logic       name_seen;
    logic       name_closed;

    t_out expected_results[$];
    int   mismatches = 0;

    task automatic clear_report();
        pos = '0;
        remaining = '0;
        phase = PH_LEN;
        kind = KIND_OTHER;
        stopped = 1'b0;
        flags_seen = 1'b0;
        flags_held = '0;
        name_seen = 1'b0;
        name_closed = 1'b0;
    endtask

    function automatic logic filter_verdict();
        case (mode)
            MODE_NONE:    return 1'b1;
            MODE_LIMITED: return flags_seen && ((flags_held & BIT_LIMITED) != 0);
            MODE_GENERAL: return flags_seen && ((flags_held & (BIT_LIMITED | BIT_GENERAL)) != 0);
            default:      return 1'b0;
        endcase
    endfunction

    function automatic string show(input t_out r);
        return $sformatf("nv=%0b nb=%02h done=%0b acc=%0b ff=%0b fv=%02h nf=%0b",
                         r.name_valid, r.name_byte, r.report_done, r.accepted,
                         r.flags_found, r.flags_value, r.name_found);
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endtask

    // Advance the record walk by one payload byte and queue the result it causes.
    task automatic walk_byte(input t_in item);
        int unsigned span;
        logic        emit;
        logic [7:0]  emit_byte;
        t_out        res;
        if (item.first_byte) clear_report();
        span = item.report_length;
        if (span > MAX_PAYLOAD) span = MAX_PAYLOAD;
        emit = 1'b0;
        emit_byte = '0;
        if (!stopped && pos < span) begin
            case (phase)
                PH_LEN: begin
                    if (item.data_byte == 8'h00 ||
                        int'(pos) + 1 + int'(item.data_byte) > int'(span)) begin
                        stopped = 1'b1;
                    end else begin
                        remaining = item.data_byte;
                        phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    remaining = remaining - 8'd1;
                    kind = KIND_OTHER;
                    if (item.data_byte == AD_FLAGS && !flags_seen) begin
                        kind = KIND_FLAGS;
                    end else if ((item.data_byte == AD_NAME_SHORT ||
                                  item.data_byte == AD_NAME_COMPLETE) && !name_closed) begin
                        // the first name record ends the search whether or not it fits
                        name_closed = 1'b1;
                        if (remaining <= name_limit) begin
                            name_seen = 1'b1;
                            kind = KIND_NAME;
                        end
                    end
                    phase = (remaining != 8'd0) ? PH_VALUE : PH_LEN;
                end
                default: begin
                    if (kind == KIND_FLAGS && !flags_seen) begin
                        flags_held = item.data_byte;
                        flags_seen = 1'b1;
                    end else if (kind == KIND_NAME) begin
                        emit = 1'b1;
                        emit_byte = item.data_byte;
                    end
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) phase = PH_LEN;
                end
            endcase
        end
        if (pos < 5'd31) pos = pos + 5'd1;

        if (emit || item.last_byte) begin
            res.name_valid = emit;
            res.name_byte = emit_byte;
            res.report_done = item.last_byte;
            res.accepted = item.last_byte ? filter_verdict() : 1'b0;
            res.flags_found = flags_seen;
            res.flags_value = flags_held;
            res.name_found = name_seen;
            expected_results.push_back(res);
        end
        if (item.last_byte) clear_report();
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            flag_error({"result with nothing expected: ", show(got)});
        end else begin
            want = expected_results.pop_front();
            if (got.name_valid !== want.name_valid || got.name_byte !== want.name_byte ||
                got.report_done !== want.report_done || got.accepted !== want.accepted ||
                got.flags_found !== want.flags_found || got.flags_value !== want.flags_value ||
                got.name_found !== want.name_found) begin
                flag_error({"result mismatch: expected ", show(want), " got ", show(got)});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = MODE_NONE;
            name_limit = 8'hFF;
            clear_report();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISCOVERY_MODE:  mode = t_mode'(i_cfg_wdata[1:0]);
                    CFG_MAX_NAME_LENGTH: name_limit = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) walk_byte(i_in_data);
            if (i_out_valid && i_out_ready) check_result(i_out_data);
        end
        o_pending = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

>>> bench/testbench.sv
// Top of the bench for the BLE advertising flags/name parser: clock, reset, byte
// stimulus, result back-pressure, register settings, watchdog and verdict.
// Depends on bafnp_pkg, ble_adv_flags_name_parser and adv_walk_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bafnp_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 4;    // margin for a byte still in flight
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTING_COUNT    = 8;
    localparam int PHASE_ITEMS      = 205;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in        i_data;
    logic       o_valid;
    logic       i_ready;
    t_out       o_data;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_wdata;

    int fail_count;
    int pending;

    // Handshake between the stimulus and the result sink for the long hold-off.
    logic hold_request = 1'b0;
    logic hold_served  = 1'b0;

    // When set, the sender offers bytes back to back for the current report.
    logic sender_calm = 1'b0;

    int unsigned items_sent = 0;
    logic [7:0]  payload_bytes[$];

    // Register plan, one entry per phase; the last phase draws random values.
    logic [1:0] mode_plan  [0:SETTING_COUNT-1] = '{MODE_NONE, MODE_LIMITED, MODE_GENERAL,
                                                   MODE_UNKNOWN, MODE_LIMITED, MODE_GENERAL,
                                                   MODE_NONE, MODE_NONE};
    logic [7:0] limit_plan [0:SETTING_COUNT-1] = '{8'd255, 8'd0, 8'd3, 8'd255,
                                                   8'd8, 8'd1, 8'd30, 8'd0};

    ble_adv_flags_name_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    adv_walk_checker u_walk_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte and hold it until the transfer. Enter and leave on a rising edge.
    task automatic send_byte(input t_in item);
        int gap;
        gap = 0;
        if (!sender_calm && $urandom_range(0, 3) == 0) gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        // ready is stable mid-cycle; the transfer happens at the next rising edge
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Send the bytes in payload_bytes as one report with the given framing.
    task automatic send_payload(input logic [4:0] rpt_len, input logic mark_first,
                                input logic mark_last);
        t_in item;
        int  idx;
        for (idx = 0; idx < payload_bytes.size(); idx++) begin
            item.data_byte = payload_bytes[idx];
            item.report_length = rpt_len;
            item.first_byte = mark_first && (idx == 0);
            item.last_byte = mark_last && (idx == payload_bytes.size() - 1);
            send_byte(item);
        end
    endtask

    // Drop valid and hold until every predicted result has been delivered.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        // a byte that causes no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle. Enter and leave on a rising edge.
    task automatic apply_setting(input t_mode mode, input logic [7:0] limit);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_DISCOVERY_MODE;
        i_cfg_wdata <= {6'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_NAME_LENGTH;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Build and send one report: mostly well-formed records with random content,
    // sometimes broken framing, sometimes plain noise.
    task automatic random_report();
        int unsigned span;
        int unsigned pos;
        int unsigned room;
        int unsigned vlen;
        int unsigned roll;
        int unsigned keep;
        logic [7:0]  rec_type;
        logic [4:0]  rpt_len;
        logic        mark_first;
        logic        mark_last;
        t_in         item;
        sender_calm = ($urandom_range(0, 3) == 0);
        payload_bytes.delete();
        if ($urandom_range(0, 6) == 0) begin
            // noise: arbitrary bytes, lengths and framing bits
            repeat ($urandom_range(1, 40)) begin
                item.data_byte = 8'($urandom_range(0, 255));
                item.report_length = 5'($urandom_range(0, 31));
                item.first_byte = ($urandom_range(0, 7) == 0);
                item.last_byte = ($urandom_range(0, 7) == 0);
                send_byte(item);
            end
        end else begin
            span = $urandom_range(1, MAX_PAYLOAD);
            pos = 0;
            while (pos < span) begin
                room = span - pos;
                if (room < 2 || $urandom_range(0, 15) == 0) begin
                    // zero length or a length running past the payload stops the walk
                    if ($urandom_range(0, 1) == 0) payload_bytes.push_back(8'h00);
                    else payload_bytes.push_back(8'($urandom_range(room, 255)));
                    while (payload_bytes.size() < span)
                        payload_bytes.push_back(8'($urandom_range(0, 255)));
                    pos = span;
                end else begin
                    roll = $urandom_range(0, 9);
                    if (roll < 3) begin
                        rec_type = AD_FLAGS;
                        vlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
                    end else if (roll < 6) begin
                        rec_type = $urandom_range(0, 1) ? AD_NAME_SHORT : AD_NAME_COMPLETE;
                        vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 29)
                                                             : $urandom_range(0, 6);
                    end else begin
                        rec_type = 8'($urandom_range(0, 255));
                        vlen = $urandom_range(0, 5);
                    end
                    if (vlen > room - 2) vlen = room - 2;
                    payload_bytes.push_back(8'(vlen + 1));
                    payload_bytes.push_back(rec_type);
                    repeat (vlen) payload_bytes.push_back(8'($urandom_range(0, 255)));
                    pos += vlen + 2;
                end
            end
            rpt_len = 5'(span);
            mark_first = ($urandom_range(0, 9) != 0);
            mark_last = 1'b1;
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                // trailing bytes past the payload
                repeat ($urandom_range(1, 6)) payload_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (roll == 1) begin
                // cut the report short; the next first byte abandons it
                keep = $urandom_range(1, payload_bytes.size());
                while (payload_bytes.size() > keep) void'(payload_bytes.pop_back());
                mark_last = 1'b0;
            end else if (roll == 2) begin
                rpt_len = 5'($urandom_range(0, 31));
            end
            send_payload(rpt_len, mark_first, mark_last);
        end
    endtask

    // Result sink: random stalls with calm stretches, plus one long hold-off on request.
    initial begin : result_sink
        int   stall_left;
        int   calm_left;
        logic calm;
        stall_left = 0;
        calm_left = 0;
        calm = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                // starve the output so the block fills up and stalls its intake
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(50, 300);
            end else begin
                calm_left--;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int          setting;
        int unsigned phase_start;
        t_mode       mode;
        logic [7:0]  limit;

        // drive every input to a known value and hold reset
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_DISCOVERY_MODE;
        i_cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed reports under the reset settings (accept all, longest name).
        // Flags with a value, then a complete name that fits.
        payload_bytes = '{8'h02, AD_FLAGS, 8'h05, 8'h04, AD_NAME_COMPLETE, 8'h41, 8'h42, 8'h43};
        send_payload(5'd8, 1'b1, 1'b1);
        // Flags record with no value, then a zero-length record stops the walk.
        payload_bytes = '{8'h01, AD_FLAGS, 8'h00, 8'hFF};
        send_payload(5'd4, 1'b1, 1'b1);
        // Overrunning first record, then bytes past the payload.
        payload_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h03, AD_NAME_SHORT};
        send_payload(5'd3, 1'b1, 1'b1);
        // Empty payload without a first-byte mark: nothing is parsed.
        payload_bytes = '{8'h02, AD_NAME_SHORT, 8'h7A};
        send_payload(5'd0, 1'b0, 1'b1);
        // Largest payload length, general flag, no first-byte mark after a last byte.
        payload_bytes = '{8'h02, AD_FLAGS, 8'h02};
        send_payload(5'd31, 1'b0, 1'b1);
        drain();

        // Random phases, one register setting each, idle between them.
        for (setting = 0; setting < SETTING_COUNT; setting++) begin
            mode = t_mode'(mode_plan[setting]);
            limit = limit_plan[setting];
            if (setting == SETTING_COUNT - 1) begin
                mode = t_mode'($urandom_range(0, 3));
                limit = 8'($urandom_range(0, 255));
            end
            apply_setting(mode, limit);
            // the first phase emits names freely, so the long hold-off backs up results
            if (setting == 0) hold_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_report();
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bafnp_pkg.sv
rtl/bafnp_walker.sv
rtl/bafnp_out_fifo.sv
rtl/ble_adv_flags_name_parser.sv
bench/adv_walk_checker.sv
bench/testbench.sv
